// File: rtl/aes192_pkg.sv
// ----------------------------------------------------------------------------
// aes192_pkg
// shared types, s-box and round helper functions for the aes-192 core
// ----------------------------------------------------------------------------
package aes192_pkg;

  typedef logic [127:0] state_t;
  typedef logic [191:0] key_t;

  typedef struct packed {
    state_t state;
    key_t   key;
    logic [7:0] rcon;
  } stage_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit state, byte 0 at the top
  function automatic logic [7:0] sb(input state_t s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic state_t sub_shift(input state_t s);
    state_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = sbox(sb(s, 4*((c+r)%4)+r));
      end
    end
    return t;
  endfunction

  function automatic state_t mix(input state_t s);
    state_t t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = sb(s, 4*c);
      a1 = sb(s, 4*c+1);
      a2 = sb(s, 4*c+2);
      a3 = sb(s, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127-32*c -: 8]  = a0 ^ al ^ xtime(a0 ^ a1);
      t[119-32*c -: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
      t[111-32*c -: 8]  = a2 ^ al ^ xtime(a2 ^ a3);
      t[103-32*c -: 8]  = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // one full six-word schedule step: words w[i-6..i-1] -> w[i..i+5]
  function automatic key_t key_step(input key_t k, input logic [7:0] rc);
    key_t n;
    logic [31:0] p, t;
    p = k[31:0];
    t = {sbox(p[23:16]) ^ rc, sbox(p[15:8]), sbox(p[7:0]), sbox(p[31:24])};
    for (int j = 0; j < 6; j++) begin
      t = k[191-32*j -: 32] ^ t;
      n[191-32*j -: 32] = t;
    end
    return n;
  endfunction

endpackage

// File: rtl/aes192_if.sv
// ----------------------------------------------------------------------------
// aes192_if
// valid/ready stream channel with generic payload
// ----------------------------------------------------------------------------
interface aes192_if #(
  parameter type PAYLOAD_T = logic
);
  logic     valid;
  logic     ready;
  PAYLOAD_T data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/aes192_stage.sv
// ----------------------------------------------------------------------------
// aes192_stage
// one pipeline stage: a round on the state and, when needed, a schedule step on the key window
// ----------------------------------------------------------------------------
module aes192_stage #(
  parameter int RND  = 1,
  parameter int LAST = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  aes192_pkg::stage_t    data_i,
  output logic                  valid_o,
  output aes192_pkg::stage_t    data_o
);

  // round key words 4*RND..4*RND+3 relative to a window starting at word 6*(RND*4/6)
  localparam int Base = (4 * RND) / 6;
  localparam int Off  = 4 * RND - 6 * Base;

  aes192_pkg::stage_t d_d, d_q;
  logic valid_q;
  aes192_pkg::key_t nxt, win0, win1;
  logic [383:0] pair;
  logic [127:0] rk;
  aes192_pkg::state_t st;

  // window at stage input holds words 6*((4*(RND-1))/6) onward; advance as needed
  localparam int PrevBase = (4 * (RND - 1)) / 6;
  localparam int Adv      = Base - PrevBase;

  always_comb begin
    nxt  = aes192_pkg::key_step(data_i.key, data_i.rcon);
    win0 = (Adv != 0) ? nxt : data_i.key;
    win1 = aes192_pkg::key_step(win0, (Adv != 0) ? aes192_pkg::xtime(data_i.rcon)
                                                 : data_i.rcon);
    pair = {win0, win1};
    rk   = pair[383-32*Off -: 128];
    st   = aes192_pkg::sub_shift(data_i.state);
    if (LAST == 0) begin
      st = aes192_pkg::mix(st);
    end
    d_d.state = st ^ rk;
    d_d.key   = win0;
    d_d.rcon  = (Adv != 0) ? aes192_pkg::xtime(data_i.rcon) : data_i.rcon;
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = d_q;

endmodule

// File: rtl/aes192_reduced_round_encrypt_core.sv
// ----------------------------------------------------------------------------
// aes192_reduced_round_encrypt_core
// pipelined aes-192 encryption, one round per register stage
// ----------------------------------------------------------------------------
// path: the input key-addition register, then each round stage register, to result valid
// throughput: one block per cycle while the output does not stall, set by one round per pipeline stage
// the whole pipeline advances together and holds while the output stalls
// reset clears the stage valid bits only; data registers are not reset
module aes192_reduced_round_encrypt_core #(
  parameter int ROUNDS = 5
) (
  input  logic clk_i,
  input  logic rst_ni,
  aes192_if.sink   in_i,
  aes192_if.source out_o
);

  aes192_pkg::stage_t sd [ROUNDS+1];
  logic               sv [ROUNDS+1];
  logic               en;

  // pipeline moves when the last stage is empty or being drained
  assign en       = !sv[ROUNDS] || out_o.ready;
  assign in_i.ready = en;

  // input stage: first round key addition
  aes192_pkg::stage_t s0_d;
  logic [319:0] inp;
  assign inp = in_i.data;
  always_comb begin
    s0_d.key   = inp[191:0];
    s0_d.state = inp[319:192] ^ inp[191:64];
    s0_d.rcon  = 8'h01;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd[0] <= s0_d;
    end
  end

  // round stages
  for (genvar r = 1; r <= ROUNDS; r++) begin : g_rnd
    aes192_stage #(.RND(r), .LAST((r == ROUNDS) ? 1 : 0)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(sv[r-1]),
      .data_i (sd[r-1]),
      .valid_o(sv[r]),
      .data_o (sd[r])
    );
  end

  assign out_o.valid = sv[ROUNDS];
  assign out_o.data  = sd[ROUNDS].state;

endmodule

// File: rtl/aes192_checker.sv
// ----------------------------------------------------------------------------
// aes192_checker
// port-level checks on the core handshake behaviour
// ----------------------------------------------------------------------------
module aes192_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_ready_i,
  input logic         out_valid_i,
  input logic         out_ready_i,
  input logic [127:0] out_data_i
);

  // input side never stalls while the output is empty
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i) else $error("ready low with empty output");

  // a stalled result keeps its data
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  // ready is low while the output stalls
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i) else $error("ready during stall");

  // no result is valid as reset is released
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i) else $error("result out of reset");

endmodule

bind aes192_reduced_round_encrypt_core aes192_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the reduced-round aes-192 encryption core. A
// directed table and then random blocks and keys go in, with random gaps on
// the input and random stalls on the output. Every ciphertext is compared
// with a behavioural cipher in this file.
// ----------------------------------------------------------------------------
module tb;

  localparam int NUM_ROUNDS  = 5;
  localparam int NUM_WORDS   = 4 * (NUM_ROUNDS + 1);
  localparam int NUM_RANDOM  = 1000;
  localparam int IDLE_LIMIT  = 5000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic [63:0] key_high;
    logic [63:0] key_mid;
    logic [63:0] key_low;
  } block_in_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_t;

  logic clk_i;
  logic rst_ni;

  aes192_if #(.PAYLOAD_T(block_in_t)) in_ch ();
  aes192_if #(.PAYLOAD_T(cipher_t))   out_ch ();

  aes192_reduced_round_encrypt_core #(.ROUNDS(NUM_ROUNDS)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // substitution table, built from the field inverse and the affine map
  logic [7:0] sub_lut [256];
  cipher_t    cipher_queue [$];
  int         n_mismatch = 0;
  int         n_sent;
  int         n_checked = 0;
  int         idle_cycles = 0;
  bit         no_stall;

  function automatic logic [7:0] dbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = dbl(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  initial begin
    logic [7:0] inv;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (int b = 1; b < 256; b++)
        if (gmul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
      sub_lut[a] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^
                   rotl8(inv, 4) ^ 8'h63;
    end
  end

  // behavioural cipher: schedule, first key addition, rounds, last round
  function automatic cipher_t encrypt(input block_in_t blk);
    logic [7:0]   st [16];
    logic [7:0]   tmp [16];
    logic [7:0]   kb [24];
    logic [31:0]  w [NUM_WORDS];
    logic [31:0]  t;
    logic [127:0] plain;
    logic [191:0] key;
    logic [127:0] res;
    logic [7:0]   rc, a0, a1, a2, a3, al;
    plain = {blk.plain_high, blk.plain_low};
    key   = {blk.key_high, blk.key_mid, blk.key_low};
    for (int i = 0; i < 16; i++) st[i] = plain[127-8*i -: 8];
    for (int i = 0; i < 24; i++) kb[i] = key[191-8*i -: 8];
    rc = 8'h01;
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (i < 6) begin
        w[i] = {kb[4*i], kb[4*i+1], kb[4*i+2], kb[4*i+3]};
      end else begin
        t = w[i-1];
        if (i % 6 == 0) begin
          t = {sub_lut[t[23:16]] ^ rc, sub_lut[t[15:8]], sub_lut[t[7:0]],
               sub_lut[t[31:24]]};
          rc = dbl(rc);
        end
        w[i] = w[i-6] ^ t;
      end
    end
    for (int r = 0; r <= NUM_ROUNDS; r++) begin
      if (r > 0) begin
        // substitute and shift rows
        for (int c = 0; c < 4; c++)
          for (int j = 0; j < 4; j++)
            tmp[4*c+j] = sub_lut[st[4*((c+j)%4)+j]];
        st = tmp;
        // column mixing on all but the last round
        if (r < NUM_ROUNDS) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            st[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
            st[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
            st[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
            st[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
          end
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= w[4*r + i/4][31-8*(i%4) -: 8];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  // gap lengths: mostly none or short, now and then long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one input transaction, then an optional gap
  task automatic send_block(input block_in_t blk, input bit with_gap);
    int g;
    in_ch.valid <= 1'b1;
    in_ch.data  <= blk;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    cipher_queue.push_back(encrypt(blk));
    n_sent++;
    g = with_gap ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // output side: compare and pick the next ready level
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    cipher_t expd;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (cipher_queue.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS)
            $display("unexpected transaction: %h %h", out_ch.data.cipher_high,
                     out_ch.data.cipher_low);
        end else begin
          expd = cipher_queue.pop_front();
          n_checked++;
          if (out_ch.data.cipher_high !== expd.cipher_high ||
              out_ch.data.cipher_low !== expd.cipher_low) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
              $display("mismatch: expected %h %h, got %h %h",
                       expd.cipher_high, expd.cipher_low,
                       out_ch.data.cipher_high, out_ch.data.cipher_low);
          end
        end
      end
      if (no_stall) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left   <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // directed stimulus
  block_in_t directed [] = '{
    '{64'h0, 64'h0, 64'h0, 64'h0, 64'h0},
    '{'1, '1, '1, '1, '1},
    '{'1, '1, 64'h0, 64'h0, 64'h0},
    '{64'h0, 64'h0, '1, '1, '1},
    '{64'h8000000000000000, 64'h0, 64'h0, 64'h0, 64'h0},
    '{64'h0, 64'h1, 64'h0, 64'h0, 64'h0},
    '{64'h0, 64'h0, 64'h8000000000000000, 64'h0, 64'h0},
    '{64'h0, 64'h0, 64'h0, 64'h0, 64'h1},
    '{64'h0, 64'h0, 64'h0, 64'h0000000100000000, 64'h0},
    '{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 64'h5555555555555555,
      64'haaaaaaaaaaaaaaaa, 64'h5555555555555555},
    '{64'h0011223344556677, 64'h8899aabbccddeeff, 64'h0001020304050607,
      64'h08090a0b0c0d0e0f, 64'h1011121314151617},
    '{64'h00112233445566ff, 64'h8899aabbccddeeff, 64'h0001020304050607,
      64'h08090a0b0c0d0e0f, 64'h1011121314151617},
    '{64'h0011223344556677, 64'h8899aabbccddeeff, 64'h0001020304050607,
      64'h08090a0b0c0d0e0f, 64'h1011121314151600},
    '{64'hffffffffffffffff, 64'h0, 64'h0, 64'hffffffffffffffff, 64'h0},
    '{64'h0, 64'hffffffffffffffff, 64'hffffffffffffffff, 64'h0, 64'hffffffffffffffff}
  };

  // main sequence
  initial begin
    block_in_t blk;
    int        kind;
    n_sent       = 0;
    no_stall     = 1'b0;
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows back to back with no stalls, then again with gaps and stalls
    no_stall <= 1'b1;
    foreach (directed[i]) send_block(directed[i], 1'b0);
    no_stall <= 1'b0;
    foreach (directed[i]) send_block(directed[i], 1'b1);

    // random blocks, some stretches without gaps or stalls
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 100 == 0) no_stall <= ($urandom_range(0, 2) == 0);
      kind = $urandom_range(0, 9);
      blk = '{rand64(), rand64(), rand64(), rand64(), rand64()};
      if (kind == 0) blk.key_low = '0;
      else if (kind == 1) blk = '{rand64(), rand64(), '1, '1, rand64()};
      else if (kind == 2) blk.plain_high = ~blk.plain_low;
      send_block(blk, (n % 200) >= 50);
    end
    in_ch.valid <= 1'b0;

    // drain, then watch for stray results
    no_stall <= 1'b1;
    while (cipher_queue.size() != 0) @(posedge clk_i);
    repeat (NUM_ROUNDS + 10) @(posedge clk_i);

    $display("%0d blocks encrypted, %0d ciphertexts checked, %0d mismatches",
             n_sent, n_checked, n_mismatch);
    $display("covered field extremes, walking bits and random keys under stalls");
    if (n_mismatch == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: aes192_reduced_round_encrypt_core.f
rtl/aes192_pkg.sv
rtl/aes192_if.sv
rtl/aes192_stage.sv
rtl/aes192_reduced_round_encrypt_core.sv
rtl/aes192_checker.sv
dv/tb.sv
